// ===== src/framed_message_receiver_top_defines.svh =====
// Assertion macros shared by the framed message receiver modules.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef FRAMED_MESSAGE_RECEIVER_TOP_DEFINES_SVH
`define FRAMED_MESSAGE_RECEIVER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define FMR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define FMR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/fmr_pkg.sv =====
// Shared types and constants of the framed message receiver.
// No dependencies; used by every module of the block.
package fmr_pkg;

  localparam int DATA_W = 8;
  localparam int IDX_W  = 6;
  localparam int LEN_W  = 7;

  // Framing characters
  localparam logic [DATA_W-1:0] CH_FRAME_OPEN  = 8'h5B;
  localparam logic [DATA_W-1:0] CH_FRAME_CLOSE = 8'h5D;
  localparam logic [DATA_W-1:0] CH_LT          = 8'h3C;
  localparam logic [DATA_W-1:0] CH_GT          = 8'h3E;
  localparam logic [DATA_W:0]   SUM_MODULUS    = 9'd255;

  // Emit job queue: one entry per message bank
  localparam int JOB_DEPTH = 2;
  localparam int JOB_PTR_W = 1;
  localparam int JOB_CNT_W = 2;

  typedef enum logic [7:0] {
    PH_IDLE     = 8'b0000_0001,
    PH_WANT_LT  = 8'b0000_0010,
    PH_MESSAGE  = 8'b0000_0100,
    PH_WANT_LT2 = 8'b0000_1000,
    PH_CHECK    = 8'b0001_0000,
    PH_WANT_GT  = 8'b0010_0000,
    PH_DONE     = 8'b0100_0000,
    PH_BAD      = 8'b1000_0000
  } phase_t;

  // Message store write request from the parser
  typedef struct packed {
    logic              en;
    logic              bank;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
  } wr_req_t;

  // Emit job: which bank holds the message and how long it is
  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] len;
  } job_t;

endpackage

// ===== src/framed_message_receiver_top.sv =====
// Channel    | Dir | Handshake          | Payload
// in_        | in  | in_valid/in_ready  | in_rx_byte[7:0]
// out_       | out | out_valid/out_ready| out_data_byte, out_byte_index, out_msg_length, out_last
//
// Parser takes one byte per cycle; it holds in_ready low only while both
// message banks are queued for output. The emitter gives one result per cycle
// while a job waits and out_ready is high, from a registered store read.
// A message of n bytes gives n results (one zero result for an empty message).
// Synchronous active-low reset clears parser, queue and emitter control;
// the two-bank store (MAX_MSG_BYTES rounded up to a power of two per bank) needs no clearing pass.
// Top level of the framed message receiver; depends on fmr_pkg and submodules.
module framed_message_receiver_top #(
  parameter int MAX_MSG_BYTES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [fmr_pkg::DATA_W-1:0]  in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fmr_pkg::DATA_W-1:0]  out_data_byte,
  output logic [fmr_pkg::IDX_W-1:0]   out_byte_index,
  output logic [fmr_pkg::LEN_W-1:0]   out_msg_length,
  output logic                        out_last
);

  fmr_pkg::wr_req_t wr;
  fmr_pkg::job_t    push_job;
  fmr_pkg::job_t    head_job;
  logic             push;
  logic             pop;
  logic             job_full;
  logic             head_valid;

  // Parse incoming bytes
  fmr_front #(.MAX_MSG_BYTES(MAX_MSG_BYTES)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .job_full   (job_full),
    .wr         (wr),
    .push       (push),
    .push_job   (push_job)
  );

  // Queue validated frames
  fmr_job_fifo u_job_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (job_full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  // Emit stored messages
  fmr_back #(.MAX_MSG_BYTES(MAX_MSG_BYTES)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .wr             (wr),
    .job_valid      (head_valid),
    .job            (head_job),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data_byte  (out_data_byte),
    .out_byte_index (out_byte_index),
    .out_msg_length (out_msg_length),
    .out_last       (out_last)
  );

endmodule

// ===== src/fmr_front.sv =====
// Frame parser: checks framing and checksum, writes message bytes to the store.
// Depends on fmr_pkg; feeds fmr_job_fifo and the store in fmr_back.
module fmr_front #(
  parameter int MAX_MSG_BYTES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [fmr_pkg::DATA_W-1:0]  in_rx_byte,
  input  logic                        job_full,
  output fmr_pkg::wr_req_t            wr,
  output logic                        push,
  output fmr_pkg::job_t               push_job
);

  fmr_pkg::phase_t                  phase_r, phase_nxt;
  logic [fmr_pkg::LEN_W-1:0]        count_r, count_nxt;
  logic [fmr_pkg::DATA_W-1:0]       sum_r, sum_nxt;
  logic [fmr_pkg::DATA_W-1:0]       check_r, check_nxt;
  logic                             good_r, good_nxt;
  logic                             bank_r, bank_nxt;
  logic                             accept;
  logic [fmr_pkg::DATA_W:0]         sum_ext;
  logic [fmr_pkg::DATA_W:0]         sum_mod;

  // Stall only while both banks still wait to be emitted
  assign in_ready = !job_full;
  assign accept   = in_valid && in_ready;

  // Running sum mod 255: operands stay below twice the modulus
  assign sum_ext = {1'b0, sum_r} + {1'b0, in_rx_byte};
  assign sum_mod = (sum_ext >= fmr_pkg::SUM_MODULUS) ? (sum_ext - fmr_pkg::SUM_MODULUS)
                                                     : sum_ext;

  assign push_job = '{bank: bank_r, len: count_r};

  // Parse one byte
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    check_nxt = check_r;
    good_nxt  = good_r;
    bank_nxt  = bank_r;
    push      = 1'b0;
    wr.en     = 1'b0;
    wr.bank   = bank_r;
    wr.idx    = count_r[fmr_pkg::IDX_W-1:0];
    wr.data   = in_rx_byte;
    if (accept) begin
      priority if (in_rx_byte == fmr_pkg::CH_FRAME_OPEN) begin
        phase_nxt = fmr_pkg::PH_WANT_LT;
        count_nxt = '0;
        sum_nxt   = '0;
        check_nxt = '0;
        good_nxt  = 1'b0;
      end else if (in_rx_byte == fmr_pkg::CH_FRAME_CLOSE) begin
        phase_nxt = fmr_pkg::PH_IDLE;
        // Hand a good frame to the emitter and move to the other bank
        if (phase_r == fmr_pkg::PH_DONE && good_r) begin
          push     = 1'b1;
          bank_nxt = !bank_r;
        end
      end else begin
        unique case (phase_r)
          fmr_pkg::PH_WANT_LT: begin
            phase_nxt = (in_rx_byte == fmr_pkg::CH_LT) ? fmr_pkg::PH_MESSAGE : fmr_pkg::PH_BAD;
          end
          fmr_pkg::PH_MESSAGE: begin
            priority if (in_rx_byte == fmr_pkg::CH_GT) begin
              phase_nxt = fmr_pkg::PH_WANT_LT2;
            end else if (count_r >= fmr_pkg::LEN_W'(MAX_MSG_BYTES)) begin
              // Drop overlong frames
              phase_nxt = fmr_pkg::PH_BAD;
            end else begin
              wr.en     = 1'b1;
              count_nxt = count_r + fmr_pkg::LEN_W'(1);
              sum_nxt   = sum_mod[fmr_pkg::DATA_W-1:0];
            end
          end
          fmr_pkg::PH_WANT_LT2: begin
            phase_nxt = (in_rx_byte == fmr_pkg::CH_LT) ? fmr_pkg::PH_CHECK : fmr_pkg::PH_BAD;
          end
          fmr_pkg::PH_CHECK: begin
            check_nxt = in_rx_byte;
            phase_nxt = fmr_pkg::PH_WANT_GT;
          end
          fmr_pkg::PH_WANT_GT: begin
            if (in_rx_byte == fmr_pkg::CH_GT) begin
              good_nxt  = ({1'b0, check_r} == ({1'b0, sum_r} + 9'd1));
              phase_nxt = fmr_pkg::PH_DONE;
            end else begin
              phase_nxt = fmr_pkg::PH_BAD;
            end
          end
          fmr_pkg::PH_IDLE, fmr_pkg::PH_DONE, fmr_pkg::PH_BAD: begin
            // Ignore the byte
          end
          default: begin
            phase_nxt = fmr_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fmr_pkg::PH_IDLE;
      count_r <= '0;
      sum_r   <= '0;
      check_r <= '0;
      good_r  <= 1'b0;
      bank_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      check_r <= check_nxt;
      good_r  <= good_nxt;
      bank_r  <= bank_nxt;
    end
  end

endmodule

// ===== src/fmr_job_fifo.sv =====
// Two-entry queue of emit jobs between the parser and the emitter.
// Depends on fmr_pkg and the assertion macros header.
`include "framed_message_receiver_top_defines.svh"

module fmr_job_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fmr_pkg::job_t push_job,
  output logic          full,
  output logic          head_valid,
  output fmr_pkg::job_t head_job,
  input  logic          pop
);

  fmr_pkg::job_t                   entry_r [fmr_pkg::JOB_DEPTH];
  logic [fmr_pkg::JOB_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [fmr_pkg::JOB_CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == fmr_pkg::JOB_CNT_W'(fmr_pkg::JOB_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = entry_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + fmr_pkg::JOB_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - fmr_pkg::JOB_CNT_W'(1);
    end
  end

  // Store a new job
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + fmr_pkg::JOB_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + fmr_pkg::JOB_PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  `FMR_ASSERT_IMPL(a_job_no_overflow, full && !pop, !push, "job pushed into a full queue")
  `FMR_ASSERT_IMPL(a_job_no_underflow, pop, cnt_r != '0, "job popped from an empty queue")
  `FMR_ASSERT_NEXT(a_job_pop_frees, full && pop && !push, !full, "pop did not free a slot")

endmodule

// ===== src/fmr_back.sv =====
// Emitter: holds the two-bank message store and plays out each queued message.
// Depends on fmr_pkg and the assertion macros header.
`include "framed_message_receiver_top_defines.svh"

module fmr_back #(
  parameter int MAX_MSG_BYTES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fmr_pkg::wr_req_t            wr,
  input  logic                        job_valid,
  input  fmr_pkg::job_t               job,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fmr_pkg::DATA_W-1:0]  out_data_byte,
  output logic [fmr_pkg::IDX_W-1:0]   out_byte_index,
  output logic [fmr_pkg::LEN_W-1:0]   out_msg_length,
  output logic                        out_last
);

  localparam int AW        = (MAX_MSG_BYTES > 1) ? $clog2(MAX_MSG_BYTES) : 1;
  localparam int MEM_DEPTH = 2 * (1 << AW);

  logic [fmr_pkg::DATA_W-1:0] mem [MEM_DEPTH];
  logic [fmr_pkg::IDX_W-1:0]  k_r;
  logic                       out_valid_r;
  logic [fmr_pkg::DATA_W-1:0] data_r;
  logic [fmr_pkg::IDX_W-1:0]  idx_r;
  logic [fmr_pkg::LEN_W-1:0]  len_r;
  logic                       last_r;
  logic                       load;
  logic                       last_now;
  logic                       len_zero;

  // Load the output register whenever a job waits and the register is free or being drained
  assign len_zero = (job.len == '0);
  assign last_now = len_zero || ((fmr_pkg::LEN_W'(k_r) + fmr_pkg::LEN_W'(1)) == job.len);
  assign load     = job_valid && (!out_valid_r || out_ready);
  // Release the bank once its last byte has been read
  assign pop      = load && last_now;

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[{wr.bank, wr.idx[AW-1:0]}] <= wr.data;
    end
  end

  // Registered read port doubles as the output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= len_zero ? '0 : mem[{job.bank, k_r[AW-1:0]}];
      idx_r  <= k_r;
      len_r  <= job.len;
      last_r <= last_now;
    end
  end

  // Output valid and byte counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        k_r         <= last_now ? '0 : (k_r + fmr_pkg::IDX_W'(1));
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_byte  = data_r;
  assign out_byte_index = idx_r;
  assign out_msg_length = len_r;
  assign out_last       = last_r;

  `FMR_ASSERT_IMPL(a_empty_single, out_valid && out_msg_length == '0, out_last && out_byte_index == '0 && out_data_byte == '0, "empty message must give one zero result")
  `FMR_ASSERT_IMPL(a_index_in_range, out_valid && out_msg_length != '0, fmr_pkg::LEN_W'(out_byte_index) < out_msg_length, "byte index beyond message length")
  `FMR_ASSERT_IMPL(a_last_at_end, out_valid && out_last && out_msg_length != '0, (fmr_pkg::LEN_W'(out_byte_index) + fmr_pkg::LEN_W'(1)) == out_msg_length, "last mark not on final byte")

endmodule
